@@ rtl/core/dsv_pkg.sv @@
// Shared types, constants and the parse state record of the date string validator.
package dsv_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned DayWidth   = 7;
  localparam int unsigned MonthWidth = 7;
  localparam int unsigned YearWidth  = 14;
  localparam int unsigned CountWidth = 3;

  localparam logic [CharWidth-1:0] CharSlash = 8'h2F;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;

  localparam logic [CountWidth-1:0] ShortFieldDigits = 3'd2;
  localparam logic [CountWidth-1:0] YearFieldDigits  = 3'd4;

  localparam logic [MonthWidth-1:0] MonthFeb  = 7'd2;
  localparam logic [MonthWidth-1:0] MonthMax  = 7'd12;
  localparam logic [DayWidth-1:0]   DayMax    = 7'd31;
  localparam logic [DayWidth-1:0]   DayShort  = 7'd30;
  localparam logic [DayWidth-1:0]   DayFeb    = 7'd28;
  localparam logic [DayWidth-1:0]   DayFebLp  = 7'd29;
  localparam logic [YearWidth-1:0]  YearMin   = 14'd10;
  localparam logic [YearWidth-1:0]  YearMax   = 14'd9999;

  typedef enum logic [1:0] {
    FIELD_DAY   = 2'd0,
    FIELD_MONTH = 2'd1,
    FIELD_YEAR  = 2'd2
  } dsv_field_e;

  typedef struct packed {
    dsv_field_e                  field;
    logic [CountWidth-1:0]       digit_cnt;
    logic [DayWidth-1:0]         day;
    logic [MonthWidth-1:0]       month;
    logic [YearWidth-1:0]        year;
    logic [3:0][3:0]             year_bcd;
    logic                        fmt_err;
  } dsv_state_t;

  localparam dsv_state_t StateReset = '{
    field:     FIELD_DAY,
    digit_cnt: '0,
    day:       '0,
    month:     '0,
    year:      '0,
    year_bcd:  '0,
    fmt_err:   1'b0
  };

endpackage

@@ rtl/core/dsv_parser.sv @@
// Character parser: field tracking, digit counting and value accumulation.
module dsv_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [dsv_pkg::CharWidth-1:0] char_i,
  input  logic                          final_i,
  output dsv_pkg::dsv_state_t           post_o
);
  import dsv_pkg::*;

  dsv_state_t state_q, state_d, nxt;
  logic       is_digit;
  logic [3:0] digit;
  logic [CountWidth-1:0] lim;

  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign digit    = char_i[3:0];
  assign lim      = (state_q.field == FIELD_YEAR) ? YearFieldDigits : ShortFieldDigits;

  always_comb begin
    nxt = state_q;
    if (char_i == CharSlash) begin
      if (state_q.field == FIELD_YEAR || state_q.digit_cnt == '0) begin
        nxt.fmt_err = 1'b1;
      end else begin
        nxt.field     = (state_q.field == FIELD_DAY) ? FIELD_MONTH : FIELD_YEAR;
        nxt.digit_cnt = '0;
      end
    end else if (is_digit) begin
      if (state_q.digit_cnt >= lim) begin
        nxt.fmt_err = 1'b1;
      end else begin
        nxt.digit_cnt = state_q.digit_cnt + 3'd1;
        case (state_q.field)
          FIELD_DAY: begin
            nxt.day = DayWidth'(10'(state_q.day) * 10'd10 + 10'(digit));
          end
          FIELD_MONTH: begin
            nxt.month = MonthWidth'(10'(state_q.month) * 10'd10 + 10'(digit));
          end
          default: begin
            nxt.year     = YearWidth'(18'(state_q.year) * 18'd10 + 18'(digit));
            nxt.year_bcd = {state_q.year_bcd[2:0], digit};
          end
        endcase
      end
    end else begin
      nxt.fmt_err = 1'b1;
    end
  end

  // A final character hands its state on and returns the parser to the start.
  always_comb begin
    state_d = state_q;
    if (take_i) begin
      state_d = final_i ? StateReset : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else begin
      state_q <= state_d;
    end
  end

  assign post_o = nxt;

endmodule

@@ rtl/core/dsv_judge.sv @@
// Calendar checks on a completed parse state, including the Gregorian leap rule.
module dsv_judge (
  input  dsv_pkg::dsv_state_t state_i,
  output logic                date_ok_o
);
  import dsv_pkg::*;

  // Whether the two-digit decimal number tens:units divides by four.
  function automatic logic div_by_4(input logic [3:0] tens, input logic [3:0] units);
    logic res;
    if (!tens[0]) begin
      res = units inside {4'd0, 4'd4, 4'd8};
    end else begin
      res = units inside {4'd2, 4'd6};
    end
    return res;
  endfunction

  logic leap, century;
  logic [DayWidth-1:0] max_day;
  logic form_ok, range_ok;

  // The year is held exactly as decimal digits, so the low pair decides
  // divisibility by four and one hundred, and the high pair by four hundred.
  assign century = (state_i.year_bcd[1] == 4'd0) && (state_i.year_bcd[0] == 4'd0);
  assign leap    = century ? div_by_4(state_i.year_bcd[3], state_i.year_bcd[2])
                           : div_by_4(state_i.year_bcd[1], state_i.year_bcd[0]);

  always_comb begin
    if (state_i.month == MonthFeb) begin
      max_day = leap ? DayFebLp : DayFeb;
    end else if (state_i.month inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
      max_day = DayShort;
    end else begin
      max_day = DayMax;
    end
  end

  assign form_ok = !state_i.fmt_err && (state_i.field == FIELD_YEAR) &&
                   (state_i.digit_cnt == ShortFieldDigits ||
                    state_i.digit_cnt == YearFieldDigits);

  assign range_ok = (state_i.month != '0) && (state_i.month <= MonthMax) &&
                    (state_i.year >= YearMin) && (state_i.year <= YearMax) &&
                    (state_i.day != '0) && (state_i.day <= DayMax);

  assign date_ok_o = form_ok && range_ok && (state_i.day <= max_day);

endmodule

@@ rtl/core/date_string_validator.sv @@
// Top level: input register, parser and checks, result register.
// A character is held in the input register and parsed from there; a final
// character's result is captured in the result register, which drives out_valid_o.
// Throughput: one character per cycle, set by the single input and result register.
// Only a final character meeting a held result waits for that result to be taken.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to the day field.
module date_string_validator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dsv_pkg::CharWidth-1:0]  char_in_i,
  input  logic                           is_final_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           date_ok_o,
  output logic [dsv_pkg::DayWidth-1:0]   day_value_o,
  output logic [dsv_pkg::MonthWidth-1:0] month_value_o,
  output logic [dsv_pkg::YearWidth-1:0]  year_value_o
);
  import dsv_pkg::*;

  logic                 s1_valid_q, s1_valid_d;
  logic [CharWidth-1:0] s1_char_q;
  logic                 s1_final_q;
  logic                 out_free, consume, in_fire;
  dsv_state_t           post;
  logic                 ok;

  logic                  res_valid_q, res_valid_d;
  logic                  res_ok_q;
  logic [DayWidth-1:0]   res_day_q;
  logic [MonthWidth-1:0] res_month_q;
  logic [YearWidth-1:0]  res_year_q;

  // Ordinary characters never need the result slot; only a final one waits.
  assign out_free   = !res_valid_q || out_ready_i;
  assign consume    = s1_valid_q && (!s1_final_q || out_free);
  assign in_ready_o = !s1_valid_q || consume;
  assign in_fire    = in_valid_i && in_ready_o;

  dsv_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (consume),
    .char_i  (s1_char_q),
    .final_i (s1_final_q),
    .post_o  (post)
  );

  dsv_judge u_judge (
    .state_i   (post),
    .date_ok_o (ok)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (consume) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (consume && s1_final_q) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q  <= char_in_i;
      s1_final_q <= is_final_i;
    end
    if (consume && s1_final_q) begin
      res_ok_q    <= ok;
      res_day_q   <= post.day;
      res_month_q <= post.month;
      res_year_q  <= post.year;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign date_ok_o     = res_ok_q;
  assign day_value_o   = res_day_q;
  assign month_value_o = res_month_q;
  assign year_value_o  = res_year_q;

endmodule

@@ rtl/core/dsv_checker.sv @@
// Port-level checker for the date string validator, with its bind statement.
module dsv_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           date_ok_o,
  input logic [dsv_pkg::DayWidth-1:0]   day_value_o,
  input logic [dsv_pkg::MonthWidth-1:0] month_value_o,
  input logic [dsv_pkg::YearWidth-1:0]  year_value_o
);
  import dsv_pkg::*;

  // A stalled result request stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(date_ok_o) && $stable(day_value_o) &&
      $stable(month_value_o) && $stable(year_value_o))
    else $error("result payload changed while stalled");

  // A date reported valid lies within the calendar ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && date_ok_o |-> month_value_o != '0 && month_value_o <= MonthMax &&
      day_value_o != '0 && day_value_o <= DayMax &&
      year_value_o >= YearMin && year_value_o <= YearMax)
    else $error("valid date outside calendar ranges");

  // Short months and February never accept too many days.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && date_ok_o && (month_value_o == MonthFeb) |-> day_value_o <= DayFebLp)
    else $error("February accepted with too many days");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && date_ok_o &&
      (month_value_o == 7'd4 || month_value_o == 7'd6 ||
       month_value_o == 7'd9 || month_value_o == 7'd11) |-> day_value_o <= DayShort)
    else $error("thirty-day month accepted with thirty-one days");

endmodule

bind date_string_validator dsv_checker u_dsv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .date_ok_o     (date_ok_o),
  .day_value_o   (day_value_o),
  .month_value_o (month_value_o),
  .year_value_o  (year_value_o)
);

@@ test/tb.sv @@
// Testbench for the date string validator: a directed table, then random date strings.
`timescale 1ns / 1ps

module tb;
  import dsv_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomChars = 1200;
  localparam int unsigned DirRows     = 28;

  typedef struct packed {
    logic                  ok;
    logic [DayWidth-1:0]   day;
    logic [MonthWidth-1:0] month;
    logic [YearWidth-1:0]  year;
  } date_res_t;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 fin;
    logic                 typed;
    date_res_t            want;
  } dir_row_t;

  // Rows with typed set carry their own expected result; the rest go through the parser copy.
  localparam dir_row_t DirTable [DirRows] = '{
    '{"2",   1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{"2",   1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{"2",   1'b0, 1'b0, '0},
    '{"0",   1'b0, 1'b0, '0},
    '{"0",   1'b0, 1'b0, '0},
    '{"0",   1'b1, 1'b1, '{1'b1, 7'd29, 7'd2, 14'd2000}},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 7'd0, 7'd0, 14'd0}},
    '{"/",   1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{1'b0, 7'd0, 7'd0, 14'd0}},
    '{"1",   1'b0, 1'b0, '0},
    '{"2",   1'b0, 1'b0, '0},
    '{"3",   1'b1, 1'b1, '{1'b0, 7'd12, 7'd0, 14'd0}},
    '{"1",   1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0},
    '{"/",   1'b1, 1'b1, '{1'b0, 7'd1, 7'd1, 14'd1}},
    '{"3",   1'b0, 1'b0, '0},
    '{"1",   1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{"4",   1'b0, 1'b0, '0},
    '{"/",   1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0},
    '{"9",   1'b1, 1'b0, '0}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [CharWidth-1:0]  char_in_i   = '0;
  logic                  is_final_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  date_ok_o;
  logic [DayWidth-1:0]   day_value_o;
  logic [MonthWidth-1:0] month_value_o;
  logic [YearWidth-1:0]  year_value_o;

  // Parser copy, advanced once per accepted request.
  dsv_field_e            cur_field;
  logic [CountWidth-1:0] digit_cnt;
  logic [DayWidth-1:0]   day_sum;
  logic [MonthWidth-1:0] month_sum;
  logic [YearWidth-1:0]  year_sum;
  logic                  malformed;

  date_res_t             pending_dates[$];
  logic [CharWidth-1:0]  text[$];
  bit                    steady = 1'b0;
  int unsigned           mismatches = 0;
  int unsigned           stall_cycles = 0;

  date_string_validator u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_in_i,
    .is_final_i,
    .out_valid_o,
    .out_ready_i,
    .date_ok_o,
    .day_value_o,
    .month_value_o,
    .year_value_o
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    cur_field = FIELD_DAY;
    digit_cnt = '0;
    day_sum   = '0;
    month_sum = '0;
    year_sum  = '0;
    malformed = 1'b0;
  endfunction

  function automatic logic is_calendar_date();
    int unsigned         y;
    logic [DayWidth-1:0] lastday;
    logic                leap;
    y = 32'(year_sum);
    if (malformed || cur_field != FIELD_YEAR) return 1'b0;
    if (digit_cnt != ShortFieldDigits && digit_cnt != YearFieldDigits) return 1'b0;
    if (month_sum < 1 || month_sum > MonthMax) return 1'b0;
    if (year_sum < YearMin || year_sum > YearMax) return 1'b0;
    if (day_sum < 1 || day_sum > DayMax) return 1'b0;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    if (month_sum == MonthFeb) begin
      lastday = leap ? DayFebLp : DayFeb;
    end else if (month_sum inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
      lastday = DayShort;
    end else begin
      lastday = DayMax;
    end
    return day_sum <= lastday;
  endfunction

  // Returns 1 when the character closes a string, with the date it yields in res.
  function automatic logic parse_char(input logic [CharWidth-1:0] c, input logic fin,
                                      output date_res_t res);
    logic [3:0] d;
    res = '0;
    if (c == CharSlash) begin
      if (cur_field == FIELD_YEAR || digit_cnt == 0) begin
        malformed = 1'b1;
      end else begin
        cur_field = (cur_field == FIELD_DAY) ? FIELD_MONTH : FIELD_YEAR;
        digit_cnt = '0;
      end
    end else if (c >= CharZero && c <= CharNine) begin
      d = 4'(c - CharZero);
      if (digit_cnt >= ((cur_field == FIELD_YEAR) ? YearFieldDigits : ShortFieldDigits)) begin
        malformed = 1'b1;
      end else begin
        digit_cnt = digit_cnt + 3'd1;
        case (cur_field)
          FIELD_DAY:   day_sum   = day_sum * 7'd10 + 7'(d);
          FIELD_MONTH: month_sum = month_sum * 7'd10 + 7'(d);
          default:     year_sum  = year_sum * 14'd10 + 14'(d);
        endcase
      end
    end else begin
      malformed = 1'b1;
    end
    if (!fin) return 1'b0;
    res.ok    = is_calendar_date();
    res.day   = day_sum;
    res.month = month_sum;
    res.year  = year_sum;
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void push_number(input int unsigned value, input int unsigned n);
    int unsigned div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      text.push_back(8'(CharZero + (value / div) % 10));
      div /= 10;
    end
  endfunction

  // Mostly well-formed dates near the calendar edges, some damaged, the rest plain noise.
  function automatic void build_date_string();
    int unsigned dd;
    int unsigned mm;
    int unsigned yy;
    int unsigned ylen;
    int unsigned pos;
    text.delete();
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(99) < 20) begin
        dd = 28 + $urandom_range(3);
      end else if ($urandom_range(99) < 85) begin
        dd = $urandom_range(31, 1);
      end else begin
        dd = $urandom_range(99);
      end
      mm = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(99);
      case ($urandom_range(19))
        0:       ylen = 1;
        1:       ylen = 3;
        2:       ylen = 5;
        3, 4, 5: ylen = 2;
        default: ylen = 4;
      endcase
      if (ylen == 4 && $urandom_range(3) == 0) begin
        case ($urandom_range(7))
          0:       yy = 2000;
          1:       yy = 1900;
          2:       yy = 2024;
          3:       yy = 2023;
          4:       yy = 1600;
          5:       yy = 2100;
          6:       yy = 9999;
          default: yy = 10;
        endcase
      end else begin
        yy = $urandom_range(10 ** ylen - 1);
      end
      push_number(dd, (dd < 10 && $urandom_range(1) == 1) ? 1 : 2);
      text.push_back(CharSlash);
      push_number(mm, (mm < 10 && $urandom_range(1) == 1) ? 1 : 2);
      text.push_back(CharSlash);
      push_number(yy, ylen);
      if ($urandom_range(99) < 20) begin
        pos = $urandom_range(text.size() - 1);
        case ($urandom_range(2))
          0:       text[pos] = 8'($urandom_range(255));
          1:       text.insert(pos, CharSlash);
          default: while (text.size() > pos + 1) void'(text.pop_back());
        endcase
      end
    end else begin
      repeat ($urandom_range(10, 1)) begin
        case ($urandom_range(3))
          0:       text.push_back(CharSlash);
          1, 2:    text.push_back(8'(CharZero + $urandom_range(9)));
          default: text.push_back(8'($urandom_range(255)));
        endcase
      end
    end
  endfunction

  // Presents one character and returns at the edge where the request is taken.
  task automatic send_char(input logic [CharWidth-1:0] c, input logic fin);
    if (!steady && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    is_final_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 15);
  end

  always @(posedge clk_i) begin : check_dates
    date_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        $error("result with no date outstanding: ok %0d day %0d month %0d year %0d",
               date_ok_o, day_value_o, month_value_o, year_value_o);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        if (date_ok_o !== want.ok) begin
          $error("date_ok: expected %0d, actual %0d", want.ok, date_ok_o);
          mismatches++;
        end
        if (day_value_o !== want.day) begin
          $error("day_value: expected %0d, actual %0d", want.day, day_value_o);
          mismatches++;
        end
        if (month_value_o !== want.month) begin
          $error("month_value: expected %0d, actual %0d", want.month, month_value_o);
          mismatches++;
        end
        if (year_value_o !== want.year) begin
          $error("year_value: expected %0d, actual %0d", want.year, year_value_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    date_res_t   got;
    int unsigned sent;
    int unsigned strings;
    sent    = 0;
    strings = 0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirTable[i]) begin
      send_char(DirTable[i].ch, DirTable[i].fin);
      if (parse_char(DirTable[i].ch, DirTable[i].fin, got)) begin
        pending_dates.push_back(DirTable[i].typed ? DirTable[i].want : got);
      end
    end

    while (sent < RandomChars) begin
      build_date_string();
      // A run of strings in the middle goes through with both sides always ready.
      steady <= (strings >= 40 && strings < 60);
      foreach (text[i]) begin
        send_char(text[i], i == text.size() - 1);
        if (parse_char(text[i], i == text.size() - 1, got)) pending_dates.push_back(got);
        sent++;
      end
      strings++;
    end

    steady     <= 1'b0;
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ date_string_validator.f @@
rtl/core/dsv_pkg.sv
rtl/core/dsv_parser.sv
rtl/core/dsv_judge.sv
rtl/core/date_string_validator.sv
rtl/core/dsv_checker.sv
test/tb.sv
